// ===== rtl/kls_pkg.sv =====
// ----------------------------------------------------------------------------
// kls_pkg
// Shared types and constants for the k-th largest stream tracker.
// ----------------------------------------------------------------------------
package kls_pkg;

    localparam int VALUE_W      = 32;
    localparam int RANK_W       = 7;
    localparam int CAPACITY_DEF = 64;

    localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] kth_value;
        logic                      found;
    } t_out;

    // Per-cell control from the top level.
    typedef struct packed {
        logic en;        // an item is accepted this cycle
        logic clr;       // the item closes the set
        logic in_range;  // cell index is below the active limit
        logic tail;      // cell is the last one inside the limit
    } t_cell_ctl;

    // What a cell shows its right-hand neighbor.
    typedef struct packed {
        logic                      keep;
        logic                      occ;
        logic signed [VALUE_W-1:0] val;
    } t_link;

endpackage

// ===== rtl/kth_largest_stream_tracker.sv =====
// ----------------------------------------------------------------------------
// kth_largest_stream_tracker
// Keeps the k largest values of a set (at most CAPACITY) in a sorted row of
// cells and reports the k-th largest when the last item of the set arrives.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle when o_in_ready is high; every cell compares
//   against the new item and shifts in the same cycle, so the row inserts
//   in a single step. The result is valid in the cycle after the last item.
// Reset: rank returns to 1, the row is empty and no result is pending.
// ----------------------------------------------------------------------------
module kth_largest_stream_tracker #(
    parameter int CAPACITY = kls_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  kls_pkg::t_in                 i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output kls_pkg::t_out                o_out,
    input  logic                         i_cfg_we,
    input  logic [kls_pkg::RANK_W-1:0]   i_cfg_data
);
    import kls_pkg::*;

    localparam int LIM_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (LIM_W > RANK_W) ? LIM_W : RANK_W;

    logic [RANK_W-1:0]         r_k_rank;
    logic [RANK_W-1:0]         k_eff;
    logic [CMP_W-1:0]          k_ext;
    logic [CMP_W-1:0]          lim;
    logic                      rank_fits;
    logic                      in_acc;
    logic                      r_out_valid;
    logic                      n_out_valid;
    t_out                      r_out;
    t_out                      n_out;
    t_link                     links [CAPACITY+1];
    t_cell_ctl                 ctl [CAPACITY];
    logic signed [VALUE_W-1:0] tap_value [CAPACITY];
    logic [CAPACITY-1:0]       tap_occ;
    logic [CAPACITY-1:0]       occ_vec;
    logic signed [VALUE_W-1:0] sel_value;
    logic                      sel_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_rank <= RANK_RESET;
        end else if (i_cfg_we) begin
            r_k_rank <= i_cfg_data;
        end
    end

    always_comb begin
        // A rank of zero behaves as one.
        k_eff     = (r_k_rank == '0) ? RANK_W'(1) : r_k_rank;
        k_ext     = CMP_W'(k_eff);
        rank_fits = (k_ext <= CMP_W'(CAPACITY));
        lim       = rank_fits ? k_ext : CMP_W'(CAPACITY);
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // The first cell sees an always-keeping, always-occupied left neighbor.
    assign links[0].keep = 1'b1;
    assign links[0].occ  = 1'b1;
    assign links[0].val  = i_in.value;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign ctl[i].en       = in_acc;
        assign ctl[i].clr      = i_in.last;
        assign ctl[i].in_range = (CMP_W'(i) < lim);
        assign ctl[i].tail     = (CMP_W'(i + 1) == lim);
        assign occ_vec[i]      = links[i+1].occ;

        kls_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl[i]),
            .i_value     (i_in.value),
            .i_prev      (links[i]),
            .o_link      (links[i+1]),
            .o_tap_value (tap_value[i]),
            .o_tap_occ   (tap_occ[i])
        );
    end

    // Only the tail cell drives its tap, so an OR picks its value.
    always_comb begin
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_value = sel_value | tap_value[i];
        end
        sel_occ = |tap_occ;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (in_acc && i_in.last) begin
            n_out_valid     = 1'b1;
            n_out.found     = rank_fits && sel_occ;
            n_out.kth_value = (rank_fits && sel_occ) ? sel_value : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Occupied cells form a contiguous run from the head of the row.
    a_occ_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((occ_vec >> 1) & ~occ_vec) == '0)
        else $error("occupied cells are not contiguous");

    // The item that closes a set empties the row.
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last) |=> (occ_vec == '0))
        else $error("row not empty after the last item");

    // The last item of a set always yields a pending result.
    a_result_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last) |=> o_out_valid)
        else $error("no result after the last item");

    // A missing rank reports zero.
    a_zero_when_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.found) |-> (o_out.kth_value == '0))
        else $error("nonzero value without found");

endmodule

// ===== rtl/kls_cell.sv =====
// ----------------------------------------------------------------------------
// kls_cell
// One slot of the descending sorted row; keeps its value or takes the new
// item or its left neighbor's value on each accepted item.
// ----------------------------------------------------------------------------
module kls_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kls_pkg::t_cell_ctl                i_ctl,
    input  logic signed [kls_pkg::VALUE_W-1:0] i_value,
    input  kls_pkg::t_link                    i_prev,
    output kls_pkg::t_link                    o_link,
    output logic signed [kls_pkg::VALUE_W-1:0] o_tap_value,
    output logic                              o_tap_occ
);
    import kls_pkg::*;

    logic                      r_occ;
    logic                      n_occ;
    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] n_val;
    logic                      occ_eff;
    logic                      keep;
    logic                      occ_upd;

    always_comb begin
        occ_eff = r_occ & i_ctl.in_range;
        // Equal values stay put, so a new item goes behind its equals.
        keep    = occ_eff && (r_val >= i_value);
        occ_upd = i_ctl.in_range && (occ_eff || i_prev.occ);

        n_val = r_val;
        if (i_ctl.en && i_ctl.in_range && !keep) begin
            n_val = i_prev.keep ? i_value : i_prev.val;
        end

        n_occ = r_occ;
        if (i_ctl.en) begin
            n_occ = i_ctl.clr ? 1'b0 : occ_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link.keep = keep;
    assign o_link.occ  = occ_eff;
    assign o_link.val  = r_val;

    assign o_tap_value = i_ctl.tail ? n_val : '0;
    assign o_tap_occ   = i_ctl.tail && occ_upd;

endmodule
